FILE: rtl/core/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg: shared types and codes for the indexed sequence store
// Transaction payloads, request and status codes, and the per-cell control
// word that the top level broadcasts along the chain of cells.
// ----------------------------------------------------------------------------
package iss_pkg;

    // request codes
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_INSERT     = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_POP_BACK   = 3'd4;
    localparam logic [2:0] OP_DELETE     = 3'd5;
    localparam logic [2:0] OP_READ       = 3'd6;
    localparam logic [2:0] OP_CLEAR      = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // cell update modes
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_OPEN  = 2'd1;  // make room at the position
    localparam logic [1:0] CELL_CLOSE = 2'd2;  // remove the entry at the position

    typedef struct packed {
        logic [2:0]         op;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [6:0]         count;
    } t_out;

    typedef struct packed {
        logic [1:0] mode;
        logic       at_pos;    // this cell sits at the target position
        logic       past_pos;  // this cell sits above the target position
    } t_cell_ctl;

endpackage

FILE: rtl/core/iss_cell.sv
// ----------------------------------------------------------------------------
// iss_cell: one storage cell of the chain
// Holds one word; on an open it takes the new word or its lower neighbor,
// on a close it takes its upper neighbor. Drives its word onto the read tap
// when it sits at the target position.
// ----------------------------------------------------------------------------
module iss_cell (
    input  logic               i_clk,
    input  iss_pkg::t_cell_ctl i_ctl,
    input  logic [31:0]        i_value,
    input  logic [31:0]        i_lower,
    input  logic [31:0]        i_upper,
    output logic [31:0]        o_data,
    output logic [31:0]        o_tap
);
    import iss_pkg::*;

    logic [31:0] r_data;
    logic [31:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.mode)
            CELL_OPEN: begin
                if (i_ctl.at_pos) begin
                    n_data = i_value;
                end else if (i_ctl.past_pos) begin
                    n_data = i_lower;
                end
            end
            CELL_CLOSE: begin
                if (i_ctl.at_pos || i_ctl.past_pos) begin
                    n_data = i_upper;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = i_ctl.at_pos ? r_data : 32'd0;

endmodule

FILE: rtl/core/iss_read_tree.sv
// ----------------------------------------------------------------------------
// iss_read_tree: registered OR tree over the cell read taps
// Groups of 32 taps are merged into registers; the group registers are
// merged combinationally for the caller to register.
// ----------------------------------------------------------------------------
module iss_read_tree #(
    parameter int N = 64
) (
    input  logic                 i_clk,
    input  logic [N-1:0][31:0]   i_taps,
    output logic [31:0]          o_word
);
    import iss_pkg::*;

    localparam int GROUP = 32;
    localparam int NG    = (N + GROUP - 1) / GROUP;

    logic [NG-1:0][31:0] r_grp;
    logic [NG-1:0][31:0] n_grp;

    always_comb begin
        n_grp = '0;
        for (int g = 0; g < NG; g++) begin
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < N) begin
                    n_grp[g] = n_grp[g] | i_taps[g * GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    always_comb begin
        o_word = '0;
        for (int g = 0; g < NG; g++) begin
            o_word = o_word | r_grp[g];
        end
    end

endmodule

FILE: rtl/core/indexed_sequence_store.sv
// ----------------------------------------------------------------------------
// indexed_sequence_store: bounded ordered list with insert/delete at index
// A chain of CAPACITY cells holds the list in order. Every request is one
// transaction in and one transaction out carrying read data, status and the
// new count.
// ----------------------------------------------------------------------------
//
//  channel  | valid       | stall        | payload
//  ---------+-------------+--------------+-----------------------------
//  request  | i_in_valid  | o_in_stall   | i_in  (op, position, value)
//  result   | o_out_valid | i_out_stall  | o_out (read_value, status, count)
//
//  Each request passes through these steps in order: accept, execute
//  (the whole chain shifts at once), read-tree merge, result held in the
//  output register. The read-tree merge step is there because the read
//  tree is registered. A stalled result holds the block: the next request
//  is accepted the cycle after the result transaction completes.
//  Reset (i_rst_n low, synchronous) empties the list; cell contents are not
//  cleared, since only positions below the count are ever read.
//
module indexed_sequence_store #(
    parameter int CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  iss_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output iss_pkg::t_out o_out
);
    import iss_pkg::*;

    // count needs to hold CAPACITY itself; compares run at the wider of the
    // count and the 7-bit request position
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > 7) ? CW : 7;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_SEND = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    t_in           r_req;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [1:0]    r_status;
    logic [1:0]    n_status;
    logic          r_rd_ok;
    logic          n_rd_ok;
    t_out          r_out;

    // execute-stage decision
    logic [1:0]    mode;
    logic [WW-1:0] eff_pos;
    logic [WW-1:0] pos_w;
    logic [WW-1:0] cnt_w;
    logic          full;
    logic          empty;

    // chain wiring
    t_cell_ctl                  cell_ctl [CAPACITY];
    logic [CAPACITY-1:0][31:0]  cell_data;
    logic [CAPACITY-1:0][31:0]  cell_tap;
    logic [31:0]                tree_word;

    assign pos_w = WW'(r_req.position);
    assign cnt_w = WW'(r_count);
    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);

    // Request decode. Insert checks position before full; delete and read
    // on an empty list report a bad position.
    always_comb begin
        mode     = CELL_HOLD;
        eff_pos  = pos_w;
        n_status = ST_OK;
        n_count  = r_count;
        n_rd_ok  = 1'b0;
        unique case (r_req.op)
            OP_PUSH_FRONT: begin
                eff_pos = '0;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    mode = CELL_OPEN;
                end
            end
            OP_PUSH_BACK: begin
                eff_pos = cnt_w;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    mode = CELL_OPEN;
                end
            end
            OP_INSERT: begin
                if (pos_w > cnt_w) begin
                    n_status = ST_BADPOS;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    mode = CELL_OPEN;
                end
            end
            OP_POP_FRONT: begin
                eff_pos = '0;
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    mode = CELL_CLOSE;
                end
            end
            OP_POP_BACK: begin
                eff_pos = cnt_w - WW'(1);
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    mode = CELL_CLOSE;
                end
            end
            OP_DELETE: begin
                if (pos_w >= cnt_w) begin
                    n_status = ST_BADPOS;
                end else begin
                    mode = CELL_CLOSE;
                end
            end
            OP_READ: begin
                if (pos_w >= cnt_w) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_rd_ok = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
        endcase
        if (mode == CELL_OPEN) begin
            n_count = r_count + CW'(1);
        end else if (mode == CELL_CLOSE) begin
            n_count = r_count - CW'(1);
        end
        // cells only move during the execute cycle
        if (r_state != S_EXEC) begin
            mode = CELL_HOLD;
        end
    end

    // chain of cells: each compares its own index with the target position
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [31:0] lower;
            logic [31:0] upper;

            assign cell_ctl[gi].mode     = mode;
            assign cell_ctl[gi].at_pos   = (eff_pos == WW'(gi));
            assign cell_ctl[gi].past_pos = (WW'(gi) > eff_pos);

            if (gi == 0) begin : g_first
                assign lower = 32'd0;
            end else begin : g_mid_lo
                assign lower = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign upper = cell_data[gi];
            end else begin : g_mid_hi
                assign upper = cell_data[gi+1];
            end

            iss_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl[gi]),
                .i_value (r_req.value),
                .i_lower (lower),
                .i_upper (upper),
                .o_data  (cell_data[gi]),
                .o_tap   (cell_tap[gi])
            );
        end
    endgenerate

    // taps are sampled at the end of execute, before any shift shows
    iss_read_tree #(
        .N (CAPACITY)
    ) u_read_tree (
        .i_clk  (i_clk),
        .i_taps (cell_tap),
        .o_word (tree_word)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_READ;
            S_READ: n_state = S_SEND;
            S_SEND: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_count <= n_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in;
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
        if (r_state == S_READ) begin
            r_out.read_value <= r_rd_ok ? tree_word : 32'd0;
            r_out.status     <= r_status;
            r_out.count      <= 7'(r_count);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_SEND);
    assign o_out       = r_out;

endmodule

FILE: rtl/core/iss_checker.sv
// ----------------------------------------------------------------------------
// iss_checker: port-level checks for the indexed sequence store
// Watches both transaction channels and the result payload; bound to the
// top level below.
// ----------------------------------------------------------------------------
module iss_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          o_in_stall,
    input  iss_pkg::t_in  i_in,
    input  logic          o_out_valid,
    input  logic          i_out_stall,
    input  iss_pkg::t_out o_out
);
    import iss_pkg::*;

    // a stalled result stays offered
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result valid dropped while stalled");

    // a stalled result payload does not change
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out))
        else $error("result payload changed while stalled");

    // one request in flight: an accepted request blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request accepted while one is in flight");

    // an empty-list error can only leave an empty list
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_EMPTY) |-> (o_out.count == 7'd0))
        else $error("empty status with nonzero count");

    // read data is only returned by a request that succeeded
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.read_value != 32'sd0) |-> (o_out.status == ST_OK))
        else $error("read data returned with an error status");

endmodule

bind indexed_sequence_store iss_checker u_iss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the indexed sequence store
// Drives push, insert, pop, delete, read and clear requests through the
// valid/stall request channel, mirrors the list in a behavioral copy and
// checks every result transaction (read data, status, count) in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import iss_pkg::*;

    // Behavioral copy of the list plus the queue of results it predicts.
    class seq_store_mirror #(int DEPTH = 64);
        logic signed [31:0] cells [DEPTH];
        int unsigned        fill;
        t_out               pending_results [$];
        int unsigned        mismatches;
        int unsigned        results_checked;
        int unsigned        status_seen [4];
        int unsigned        op_seen [8];
        int unsigned        peak_fill;

        local function void open_slot(int unsigned p, logic signed [31:0] w);
            for (int unsigned i = fill; i > p; i--) cells[i] = cells[i - 1];
            cells[p] = w;
            fill++;
            if (fill > peak_fill) peak_fill = fill;
        endfunction

        local function void close_slot(int unsigned p);
            for (int unsigned i = p; i + 1 < fill; i++) cells[i] = cells[i + 1];
            fill--;
        endfunction

        local function void note_failure(string msg);
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH: %s", msg);
        endfunction

        // Accepted request transaction: update the copy, queue the result.
        function void apply_request(t_in req);
            t_out        res;
            int unsigned p;
            res        = '0;
            res.status = ST_OK;
            p          = 32'(req.position);
            case (req.op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (fill >= DEPTH) res.status = ST_FULL;
                    else open_slot((req.op == OP_PUSH_FRONT) ? 0 : fill, req.value);
                end
                OP_INSERT: begin
                    // past-the-end check wins over the full check
                    if (p > fill) res.status = ST_BADPOS;
                    else if (fill >= DEPTH) res.status = ST_FULL;
                    else open_slot(p, req.value);
                end
                OP_POP_FRONT, OP_POP_BACK: begin
                    if (fill == 0) res.status = ST_EMPTY;
                    else close_slot((req.op == OP_POP_FRONT) ? 0 : fill - 1);
                end
                OP_DELETE: begin
                    if (p >= fill) res.status = ST_BADPOS;
                    else close_slot(p);
                end
                OP_READ: begin
                    if (p >= fill) res.status = ST_BADPOS;
                    else res.read_value = cells[p];
                end
                OP_CLEAR: fill = 0;
            endcase
            res.count = 7'(fill);
            op_seen[req.op]++;
            status_seen[res.status]++;
            pending_results = {pending_results, res};
        endfunction

        // Accepted result transaction: compare with the oldest prediction.
        function void check_result(t_out got);
            t_out want;
            results_checked++;
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result rd=%0d st=%0d cnt=%0d",
                                       got.read_value, got.status, got.count));
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            if (got.read_value !== want.read_value || got.status !== want.status ||
                got.count !== want.count)
                note_failure($sformatf(
                    "result %0d: expected rd=%0d st=%0d cnt=%0d, got rd=%0d st=%0d cnt=%0d",
                    results_checked, want.read_value, want.status,
                    want.count, got.read_value, got.status, got.count));
        endfunction
    endclass

    localparam int CAPACITY        = 64;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;     // long receiver hold-off for back-pressure
    localparam int DRAIN_CYCLES    = 20;

    // Traffic shapes: grow the list toward full, drain it toward empty, or mix.
    typedef enum {SEG_GROW, SEG_SHRINK, SEG_MIX} t_seg;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_stall = 1'b0;
    t_in  i_in        = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_active    = 1'b0;
    event        hold_off_ev;
    int unsigned cycles         = 0;

    // Segment schedule: two growth stretches push toward full, two drain
    // stretches push toward empty, mixed traffic in between.
    t_seg seg_plan [6] = '{SEG_GROW, SEG_GROW, SEG_MIX, SEG_SHRINK, SEG_SHRINK, SEG_MIX};
    int   seg_idx      = 5;
    int   seg_left     = 0;

    seq_store_mirror #(CAPACITY) mirror;

    indexed_sequence_store #(
        .CAPACITY    (CAPACITY)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("indexed_sequence_store test failed");
            $finish;
        end
    end

    // Result side. Values seen here are the pre-edge ones, so a transaction
    // completes when valid was high and our own stall was low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            mirror.check_result(o_out);
        i_out_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
    end

    // Long hold-off, counted here so the sender keeps offering requests
    // and the block has to stall its input.
    always begin
        @(hold_off_ev);
        hold_active <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // Offer one request after a random idle gap; returns at the edge where
    // the transaction completes, so the next call may keep valid high.
    task automatic send_request(input t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        mirror.apply_request(item);
    endtask

    task automatic issue(input logic [2:0] op, input logic [6:0] pos,
                         input logic [31:0] val);
        t_in item;
        item.op       = op;
        item.position = pos;
        item.value    = val;
        send_request(item);
    endtask

    // Random traffic with the given sender idle and receiver stall rates.
    task automatic run_phase(input int n_items, input int idle_pct,
                             input int stall_pct);
        logic [2:0]  grow_ops [3]   = '{OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT};
        logic [2:0]  shrink_ops [3] = '{OP_POP_FRONT, OP_POP_BACK, OP_DELETE};
        t_in         item;
        int unsigned r;
        send_idle_pct  = idle_pct;
        recv_stall_pct <= stall_pct;
        for (int i = 0; i < n_items; i++) begin
            if (seg_left == 0) begin
                seg_idx  = (seg_idx + 1) % 6;
                seg_left = $urandom_range(56, 24);
            end
            seg_left--;

            // op choice follows the current segment
            r = $urandom_range(99);
            case (seg_plan[seg_idx])
                SEG_GROW:   item.op = (r < 88) ? grow_ops[$urandom_range(2)]
                                    : 3'($urandom_range(OP_READ, OP_POP_FRONT));
                SEG_SHRINK: item.op = (r < 80) ? shrink_ops[$urandom_range(2)] :
                                      (r < 90) ? OP_READ : grow_ops[$urandom_range(2)];
                default:    item.op = (r < 4)  ? OP_CLEAR :
                                      (r < 30) ? OP_READ
                                    : 3'($urandom_range(OP_DELETE, OP_PUSH_FRONT));
            endcase
            // a little noise: any op at all
            if ($urandom_range(99) < 3)
                item.op = 3'($urandom_range(OP_CLEAR, OP_PUSH_FRONT));

            // mostly in-range positions, some beyond the count, a few beyond 64
            r = $urandom_range(99);
            if (r < 85) begin
                if (item.op == OP_INSERT)
                    item.position = 7'($urandom_range(mirror.fill, 0));
                else
                    item.position = (mirror.fill == 0) ? 7'd0
                                  : 7'($urandom_range(mirror.fill - 1, 0));
            end else if (r < 97) begin
                item.position = 7'($urandom_range(CAPACITY, 0));
            end else begin
                item.position = 7'($urandom_range(7'h7F, 0));
            end

            case ($urandom_range(9))
                0:       item.value = 32'h8000_0000;
                1:       item.value = 32'h7FFF_FFFF;
                2:       item.value = 32'h0;
                3:       item.value = 32'hFFFF_FFFF;
                default: item.value = $urandom;
            endcase
            send_request(item);
        end
    endtask

    initial begin
        mirror = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-list errors first
        issue(OP_POP_FRONT, 7'd0,   32'h0);
        issue(OP_POP_BACK,  7'h7F,  32'h0);
        issue(OP_DELETE,    7'd0,   32'h0);
        issue(OP_READ,      7'd0,   32'h0);
        issue(OP_INSERT,    7'd1,   32'h5);       // past the end
        issue(OP_CLEAR,     7'h7F,  32'hFFFF_FFFF);
        // build [min, -1, max, 0] with extreme words
        issue(OP_PUSH_BACK,  7'd0,  32'h7FFF_FFFF);
        issue(OP_PUSH_FRONT, 7'h7F, 32'h8000_0000);
        issue(OP_INSERT,     7'd1,  32'hFFFF_FFFF);
        issue(OP_INSERT,     7'd3,  32'h0);       // insert at the count appends
        issue(OP_INSERT,     7'd5,  32'h1);       // past the end
        for (int p = 0; p < 4; p++) issue(OP_READ, 7'(p), 32'h0);
        issue(OP_READ,   7'd4,   32'h0);          // at the count
        issue(OP_READ,   7'd64,  32'h0);
        issue(OP_READ,   7'h7F,  32'h0);
        issue(OP_DELETE, 7'd1,   32'h0);
        issue(OP_DELETE, 7'd3,   32'h0);          // at the count
        issue(OP_POP_FRONT, 7'd0, 32'h0);
        issue(OP_POP_BACK,  7'd0, 32'h0);
        issue(OP_READ,      7'd0, 32'h0);
        issue(OP_CLEAR,     7'd0, 32'h0);

        // Random phases: no idling, sender gaps, receiver stalls, both
        run_phase(150, 0,  0);
        run_phase(120, 66, 0);
        run_phase(120, 0,  66);
        run_phase(120, 27, 27);
        // Back-pressure: long receiver hold-off while requests keep coming
        -> hold_off_ev;
        run_phase(100, 0,  0);
        i_in_valid <= 1'b0;

        while (mirror.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $write("Covered %0d requests: push front/back %0d/%0d, insert %0d, ",
               mirror.op_seen.sum(), mirror.op_seen[OP_PUSH_FRONT],
               mirror.op_seen[OP_PUSH_BACK], mirror.op_seen[OP_INSERT]);
        $display("pop front/back %0d/%0d, delete %0d, read %0d, clear %0d; %0d results checked",
                 mirror.op_seen[OP_POP_FRONT], mirror.op_seen[OP_POP_BACK],
                 mirror.op_seen[OP_DELETE], mirror.op_seen[OP_READ],
                 mirror.op_seen[OP_CLEAR], mirror.results_checked);
        $write("Statuses ok %0d, bad position %0d, empty %0d, full %0d; ",
               mirror.status_seen[ST_OK], mirror.status_seen[ST_BADPOS],
               mirror.status_seen[ST_EMPTY], mirror.status_seen[ST_FULL]);
        $display("peak fill %0d of %0d; %0d mismatches",
                 mirror.peak_fill, CAPACITY, mirror.mismatches);
        if (mirror.mismatches == 0 && mirror.pending_results.size() == 0) begin
            $display("indexed_sequence_store test passed");
        end else begin
            $display("indexed_sequence_store test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/iss_pkg.sv
rtl/core/iss_cell.sv
rtl/core/iss_read_tree.sv
rtl/core/indexed_sequence_store.sv
rtl/core/iss_checker.sv
sim/tb_top.sv
